// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the SIR integrator RTL.
// Compiled out when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/sir_pkg.sv -----
// Package for the SIR integrator: widths, codes, control word and microcode ROM.
// No dependencies.
`default_nettype none
package sir_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POP_W     = 32;
  localparam int RATE_W    = 20;
  localparam int TOT_W     = POP_W + 2;
  localparam int NI_W      = POP_W + RATE_W - FRAC_BITS;
  localparam int RV_W      = NI_W + RATE_W - FRAC_BITS;
  localparam int MUL_A_W   = (NI_W > POP_W) ? NI_W : POP_W;
  localparam int PROD_W    = MUL_A_W + POP_W;
  localparam int EXT_MAX   = (NI_W > RV_W) ? NI_W : RV_W;
  localparam int EXT_W     = ((EXT_MAX > POP_W) ? EXT_MAX : POP_W) + 1;
  localparam int DIV_STEPS = POP_W + FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int PROG_LEN  = 18;
  localparam int PC_W      = $clog2(PROG_LEN);

  localparam logic [RATE_W-1:0] DT_ONE = RATE_W'(1) << FRAC_BITS;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic {CMD_LOAD, CMD_STEP} cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {REG_BETA, REG_GAMMA, REG_DT} reg_idx_t;

  typedef enum logic [1:0] {ST_OK, ST_ZERO_POP, ST_NO_LOAD} status_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_DIV_START, OP_INV_WRITE, OP_INV_ZERO, OP_COMMIT
  } op_t;

  typedef enum logic [1:0] {MA_I, MA_X, MA_GAMMA, MA_RC} ma_t;

  typedef enum logic [2:0] {MB_INV, MB_I, MB_S, MB_DT, MB_BETA} mb_t;

  typedef enum logic [2:0] {WB_NONE, WB_X_HI, WB_X_SAT, WB_RC, WB_RV, WB_NI} wb_t;

  typedef enum logic [1:0] {C_NEXT, C_NOT_LOADED, C_TOTAL_ZERO, C_DIV_BUSY} cond_t;

  typedef struct packed {
    op_t     op;
    ma_t     ma;
    mb_t     mb;
    logic    mul_en;
    wb_t     wb;
    cond_t   cond;
    pc_t     target;
    logic    last;
    status_t status;
  } ctl_t;

  typedef struct packed {
    logic loaded;
    logic total_zero;
    logic div_busy;
  } dp_status_t;

  typedef struct packed {
    logic    idle;
    logic    push;
    status_t status;
  } seq_out_t;

  localparam pc_t PC_STEP     = pc_t'(0);
  localparam pc_t PC_NO_LOAD  = pc_t'(10);
  localparam pc_t PC_LOAD     = pc_t'(11);
  localparam pc_t PC_DIV_WAIT = pc_t'(13);
  localparam pc_t PC_ZERO     = pc_t'(16);
  localparam pc_t PC_LAST     = pc_t'(PROG_LEN - 1);

  localparam ctl_t CTL_NOP =
    '{OP_NONE, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP, 1'b0, ST_OK};

  function automatic ctl_t rom(input pc_t pc);
    ctl_t w;
    unique case (pc)
      pc_t'(0):  w = '{OP_NONE, MA_I, MB_INV, 1'b1, WB_NONE, C_NOT_LOADED, PC_NO_LOAD,
                       1'b0, ST_OK};
      pc_t'(1):  w = '{OP_NONE, MA_GAMMA, MB_I, 1'b1, WB_X_HI, C_NEXT, PC_STEP, 1'b0, ST_OK};
      pc_t'(2):  w = '{OP_NONE, MA_X, MB_BETA, 1'b1, WB_RC, C_NEXT, PC_STEP, 1'b0, ST_OK};
      pc_t'(3):  w = '{OP_NONE, MA_RC, MB_DT, 1'b1, WB_X_SAT, C_NEXT, PC_STEP, 1'b0, ST_OK};
      pc_t'(4):  w = '{OP_NONE, MA_X, MB_S, 1'b1, WB_RV, C_NEXT, PC_STEP, 1'b0, ST_OK};
      pc_t'(5):  w = '{OP_NONE, MA_I, MB_I, 1'b0, WB_X_SAT, C_NEXT, PC_STEP, 1'b0, ST_OK};
      pc_t'(6):  w = '{OP_NONE, MA_X, MB_DT, 1'b1, WB_NONE, C_NEXT, PC_STEP, 1'b0, ST_OK};
      pc_t'(7):  w = '{OP_NONE, MA_I, MB_I, 1'b0, WB_NI, C_NEXT, PC_STEP, 1'b0, ST_OK};
      pc_t'(8):  w = '{OP_COMMIT, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP, 1'b0, ST_OK};
      pc_t'(9):  w = '{OP_NONE, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP, 1'b1, ST_OK};
      pc_t'(10): w = '{OP_NONE, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP, 1'b1,
                       ST_NO_LOAD};
      pc_t'(11): w = '{OP_NONE, MA_I, MB_I, 1'b0, WB_NONE, C_TOTAL_ZERO, PC_ZERO,
                       1'b0, ST_OK};
      pc_t'(12): w = '{OP_DIV_START, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP,
                       1'b0, ST_OK};
      pc_t'(13): w = '{OP_NONE, MA_I, MB_I, 1'b0, WB_NONE, C_DIV_BUSY, PC_DIV_WAIT,
                       1'b0, ST_OK};
      pc_t'(14): w = '{OP_INV_WRITE, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP,
                       1'b0, ST_OK};
      pc_t'(15): w = '{OP_NONE, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP, 1'b1, ST_OK};
      pc_t'(16): w = '{OP_INV_ZERO, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP,
                       1'b0, ST_OK};
      pc_t'(17): w = '{OP_NONE, MA_I, MB_I, 1'b0, WB_NONE, C_NEXT, PC_STEP, 1'b1,
                       ST_ZERO_POP};
      default:   w = CTL_NOP;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sir_epidemic_euler_step.sv -----
// Top level of the forward-Euler SIR integrator: ports, rate registers, result register.
// Depends on sir_pkg, sir_seq, sir_dp.
//
// Input channel (in_valid/in_ready): command 0 loads the three initial counts,
// command 1 advances one period. Every word yields one result word on the
// output channel (out_valid/out_ready) with the three counts and a status.
// Rates and time step go through cfg_we/cfg_index/cfg_data; the user writes them only
// while idle, the block does not enforce it; an index beyond the time step is ignored.
// Operation: a step word runs a 10-word microcode program on the shared 36x32
// multiplier; a load runs the bit-serial reciprocal; a load with a zero total and a
// step before any load take short paths that end with their own status. The next word
// is accepted the cycle after the previous result enters the output register, so a
// new word is never taken while the last one is still being computed.
// A result waits in the output register while the receiver stalls; the next
// word is computed meanwhile and holds at its last step until the register frees.
// Reset clears the counts, reciprocal and loaded flag, sets beta and gamma to
// zero and dt to 1.0, and empties the output register; no word is accepted in reset.
`default_nettype none
module sir_epidemic_euler_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sir_pkg::RATE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [sir_pkg::POP_W-1:0]     initial_susceptible,
  input  logic [sir_pkg::POP_W-1:0]     initial_infected,
  input  logic [sir_pkg::POP_W-1:0]     initial_recovered,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sir_pkg::POP_W-1:0]     susceptible_now,
  output logic [sir_pkg::POP_W-1:0]     infected_now,
  output logic [sir_pkg::POP_W-1:0]     recovered_now,
  output logic [1:0]                    status
);
  import sir_pkg::*;

  logic [RATE_W-1:0] beta;
  logic [RATE_W-1:0] gamma;
  logic [RATE_W-1:0] dt;
  logic              in_accept;
  logic              out_full;
  ctl_t              ctl;
  seq_out_t          so;
  dp_status_t        dps;
  logic [POP_W-1:0]  s_now;
  logic [POP_W-1:0]  i_now;
  logic [POP_W-1:0]  r_now;

  assign in_ready  = so.idle && !rst;
  assign in_accept = in_valid && in_ready;
  assign out_full  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta  <= '0;
      gamma <= '0;
      dt    <= DT_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BETA:  beta  <= cfg_data;
        REG_GAMMA: gamma <= cfg_data;
        REG_DT:    dt    <= cfg_data;
        default:   ;
      endcase
    end
  end

  sir_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_accept),
    .command  (command),
    .out_full (out_full),
    .dps      (dps),
    .ctl      (ctl),
    .so       (so)
  );

  sir_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .load_en (in_accept && (command == CMD_LOAD)),
    .init_s  (initial_susceptible),
    .init_i  (initial_infected),
    .init_r  (initial_recovered),
    .beta    (beta),
    .gamma   (gamma),
    .dt      (dt),
    .dps     (dps),
    .s_now   (s_now),
    .i_now   (i_now),
    .r_now   (r_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (so.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (so.push) begin
      susceptible_now <= s_now;
      infected_now    <= i_now;
      recovered_now   <= r_now;
      status          <= so.status;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sir_div.sv -----
// Restoring divider: fixed dividend 2^(POP_W+FRAC_BITS) over the population total.
// One quotient bit per cycle, saturating result. Depends on sir_pkg.
`default_nettype none
module sir_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sir_pkg::TOT_W-1:0] divisor,
  output logic                      busy,
  output logic [sir_pkg::POP_W-1:0] quotient
);
  import sir_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [TOT_W-1:0]     rem;
  logic [POP_W-1:0]     q;
  logic                 ovf;
  logic [TOT_W:0]       trial;
  logic [TOT_W:0]       diff;
  logic                 ge;

  assign busy     = (cnt != '0);
  assign trial    = {rem, (cnt == DIV_CNT_W'(DIV_STEPS))};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = (trial >= {1'b0, divisor});
  assign quotient = ovf ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      rem <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
      q   <= {q[POP_W-2:0], ge};
      ovf <= ovf | q[POP_W-1];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sir_dp.sv -----
// Datapath of the SIR integrator: compartments, shared multiplier, writeback, commit.
// Driven by the microcode control word. Depends on sir_pkg, sir_div, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sir_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  sir_pkg::ctl_t              ctl,
  input  logic                       load_en,
  input  logic [sir_pkg::POP_W-1:0]  init_s,
  input  logic [sir_pkg::POP_W-1:0]  init_i,
  input  logic [sir_pkg::POP_W-1:0]  init_r,
  input  logic [sir_pkg::RATE_W-1:0] beta,
  input  logic [sir_pkg::RATE_W-1:0] gamma,
  input  logic [sir_pkg::RATE_W-1:0] dt,
  output sir_pkg::dp_status_t        dps,
  output logic [sir_pkg::POP_W-1:0]  s_now,
  output logic [sir_pkg::POP_W-1:0]  i_now,
  output logic [sir_pkg::POP_W-1:0]  r_now
);
  import sir_pkg::*;

  logic [POP_W-1:0]   sus;
  logic [POP_W-1:0]   inf;
  logic [POP_W-1:0]   rec;
  logic [POP_W-1:0]   inv;
  logic               loaded;
  logic [TOT_W-1:0]   total;
  logic [POP_W-1:0]   x;
  logic [NI_W-1:0]    rc;
  logic [RV_W-1:0]    rv;
  logic [NI_W-1:0]    ni;
  logic [PROD_W-1:0]  prod;
  logic [MUL_A_W-1:0] mul_a;
  logic [POP_W-1:0]   mul_b;
  logic [PROD_W-1:0]  shifted;
  logic [POP_W-1:0]   x_sat;
  logic [EXT_W-1:0]   ni_e;
  logic [EXT_W-1:0]   rv_e;
  logic [EXT_W-1:0]   s_e;
  logic [EXT_W-1:0]   grown;
  logic [EXT_W-1:0]   rsum;
  logic [POP_W-1:0]   sus_next;
  logic [POP_W-1:0]   inf_next;
  logic [POP_W-1:0]   rec_next;
  logic               div_busy;
  logic [POP_W-1:0]   div_q;

  function automatic logic [POP_W-1:0] sat_pop(input logic [EXT_W-1:0] v);
    return (|v[EXT_W-1:POP_W]) ? '1 : v[POP_W-1:0];
  endfunction

  sir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.op == OP_DIV_START),
    .divisor  (total),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    unique case (ctl.ma)
      MA_I:     mul_a = MUL_A_W'(inf);
      MA_X:     mul_a = MUL_A_W'(x);
      MA_GAMMA: mul_a = MUL_A_W'(gamma);
      MA_RC:    mul_a = MUL_A_W'(rc);
    endcase
  end

  always_comb begin
    unique case (ctl.mb)
      MB_INV:  mul_b = inv;
      MB_I:    mul_b = inf;
      MB_S:    mul_b = sus;
      MB_DT:   mul_b = POP_W'(dt);
      MB_BETA: mul_b = POP_W'(beta);
      default: mul_b = '0;
    endcase
  end

  assign shifted = prod >> FRAC_BITS;
  assign x_sat   = (|shifted[PROD_W-1:POP_W]) ? '1 : shifted[POP_W-1:0];

  assign ni_e     = EXT_W'(ni);
  assign rv_e     = EXT_W'(rv);
  assign s_e      = EXT_W'(sus);
  assign grown    = EXT_W'(inf) + ni_e;
  assign rsum     = EXT_W'(rec) + rv_e;
  assign sus_next = (ni_e >= s_e) ? '0 : POP_W'(s_e - ni_e);
  assign inf_next = (rv_e >= grown) ? '0 : sat_pop(grown - rv_e);
  assign rec_next = sat_pop(rsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      sus    <= '0;
      inf    <= '0;
      rec    <= '0;
      inv    <= '0;
      loaded <= 1'b0;
    end else begin
      if (load_en) begin
        sus <= init_s;
        inf <= init_i;
        rec <= init_r;
      end else if (ctl.op == OP_COMMIT) begin
        sus <= sus_next;
        inf <= inf_next;
        rec <= rec_next;
      end
      if (ctl.op == OP_INV_WRITE) begin
        inv    <= div_q;
        loaded <= 1'b1;
      end else if (ctl.op == OP_INV_ZERO) begin
        inv    <= '0;
        loaded <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      total <= TOT_W'(init_s) + TOT_W'(init_i) + TOT_W'(init_r);
    end
    if (ctl.mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    unique case (ctl.wb)
      WB_NONE:  ;
      WB_X_HI:  x  <= prod[POP_W +: POP_W];
      WB_X_SAT: x  <= x_sat;
      WB_RC:    rc <= shifted[NI_W-1:0];
      WB_RV:    rv <= shifted[RV_W-1:0];
      WB_NI:    ni <= shifted[NI_W-1:0];
      default:  ;
    endcase
  end

  assign dps.loaded     = loaded;
  assign dps.total_zero = (total == '0);
  assign dps.div_busy   = div_busy;
  assign s_now          = sus;
  assign i_now          = inf;
  assign r_now          = rec;

  `ASSERT_IMPLIES(a_commit_loaded, clk, rst, ctl.op == OP_COMMIT, loaded, "step without load")
  `ASSERT_IMPLIES(a_div_nonzero, clk, rst, ctl.op == OP_DIV_START, total != '0, "divide by zero")
  `ASSERT_NEXT(a_div_runs, clk, rst, ctl.op == OP_DIV_START, div_busy, "divider not started")
  `ASSERT_IMPLIES(a_inv_ready, clk, rst, ctl.op == OP_INV_WRITE, !div_busy, "early reciprocal")

endmodule
`default_nettype wire

// ----- rtl/core/sir_seq.sv -----
// Microcode sequencer: step counter over the ROM program with conditional jumps.
// Depends on sir_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sir_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                command,
  input  logic                out_full,
  input  sir_pkg::dp_status_t dps,
  output sir_pkg::ctl_t       ctl,
  output sir_pkg::seq_out_t   so
);
  import sir_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t state;
  pc_t    pc;
  ctl_t   word;
  logic   jump;
  logic   running;

  assign word    = rom(pc);
  assign running = (state == S_RUN);

  always_comb begin
    unique case (word.cond)
      C_NEXT:       jump = 1'b0;
      C_NOT_LOADED: jump = !dps.loaded;
      C_TOTAL_ZERO: jump = dps.total_zero;
      C_DIV_BUSY:   jump = dps.div_busy;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= PC_STEP;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            pc    <= (command == CMD_STEP) ? PC_STEP : PC_LOAD;
          end
        end
        S_RUN: begin
          if (word.last) begin
            if (!out_full) begin
              state <= S_IDLE;
            end
          end else if (jump) begin
            pc <= word.target;
          end else begin
            pc <= pc + 1'b1;
          end
        end
      endcase
    end
  end

  assign ctl       = running ? word : CTL_NOP;
  assign so.idle   = !running;
  assign so.push   = running && word.last && !out_full;
  assign so.status = word.status;

  `ASSERT_IMPLIES(a_pc_in_program, clk, rst, running, pc <= PC_LAST, "pc left program")

endmodule
`default_nettype wire
